@@ rtl/motor_command_pwm_with_timeout_unit_assert.svh @@
// ----------------------------------------------------------------------------
// motor command pwm assertion macros
// shared assertion forms for the pwm block, clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_PWM_WITH_TIMEOUT_UNIT_ASSERT_SVH
`define MOTOR_COMMAND_PWM_WITH_TIMEOUT_UNIT_ASSERT_SVH

// same-cycle implication
`define MCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcp assertion failed");

// next-cycle implication
`define MCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcp assertion failed");

`endif

@@ rtl/mcp_pkg.sv @@
// ----------------------------------------------------------------------------
// mcp_pkg
// types, codes and constants shared by the motor command pwm block
// ----------------------------------------------------------------------------
package mcp_pkg;

  localparam int PWM_PERIOD_DEF = 20;
  localparam int SPEED_FULL     = 15;
  localparam int SPEED_W        = 4;
  localparam int MOVE_W         = 3;
  localparam int TIMEOUT_W      = 16;
  localparam int CHAN_N         = 4;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;

  // move codes
  localparam logic [MOVE_W-1:0] MOVE_STOP       = 3'd0;
  localparam logic [MOVE_W-1:0] MOVE_FORWARD    = 3'd1;
  localparam logic [MOVE_W-1:0] MOVE_BACKWARD   = 3'd2;
  localparam logic [MOVE_W-1:0] MOVE_LEFT       = 3'd3;
  localparam logic [MOVE_W-1:0] MOVE_RIGHT      = 3'd4;
  localparam logic [MOVE_W-1:0] MOVE_FAST_RIGHT = 3'd5;
  localparam logic [MOVE_W-1:0] MOVE_FAST_LEFT  = 3'd6;

  // one input word
  typedef struct packed {
    logic               cmd;
    logic [MOVE_W-1:0]  move;
    logic [SPEED_W-1:0] speed;
  } item_t;

  // one result word
  typedef struct packed {
    logic              timed_out;
    logic [CHAN_N-1:0] pins;   // bit 0 is pin_a
  } result_t;

  // channels driven by each move, bit 0 = a ... bit 3 = d
  function automatic logic [CHAN_N-1:0] chan_mask(input logic [MOVE_W-1:0] mv);
    logic [CHAN_N-1:0] m;
    unique case (mv)
      MOVE_FORWARD:    m = 4'b0011;
      MOVE_BACKWARD:   m = 4'b1100;
      MOVE_LEFT:       m = 4'b0010;
      MOVE_RIGHT:      m = 4'b0001;
      MOVE_FAST_RIGHT: m = 4'b1001;
      MOVE_FAST_LEFT:  m = 4'b0110;
      default:         m = 4'b0000;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/mcp_core.sv @@
// ----------------------------------------------------------------------------
// mcp_core
// held command, phase counter, idle counter and pin update for one word
// ----------------------------------------------------------------------------
module mcp_core #(
  parameter int PWM_PERIOD = mcp_pkg::PWM_PERIOD_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mcp_pkg::TIMEOUT_W-1:0]    cfg_wr_data,
  input  logic                             step,
  input  mcp_pkg::item_t                   item,
  output mcp_pkg::result_t                 result,
  output logic [mcp_pkg::SPEED_W-1:0]      held_speed
);

  localparam int PH_W = $clog2(PWM_PERIOD + 1);
  localparam int TBL_N = mcp_pkg::SPEED_FULL + 1;

  logic [mcp_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [mcp_pkg::MOVE_W-1:0]    move_r, move_nxt;
  logic [mcp_pkg::SPEED_W-1:0]   speed_r, speed_nxt;
  logic [mcp_pkg::TIMEOUT_W-1:0] idle_r, idle_nxt;
  logic [PH_W-1:0]               phase_r, phase_nxt;
  logic [mcp_pkg::CHAN_N-1:0]    pins_r, pins_nxt;
  logic [PH_W:0]                 phase_inc;
  logic [mcp_pkg::TIMEOUT_W:0]   idle_inc;
  logic [PH_W-1:0]               duty;
  logic [PH_W-1:0]               duty_tbl [TBL_N];
  logic                          chan_on;
  logic                          to_hit;

  // duty per speed, worked out at elaboration
  for (genvar k = 0; k < TBL_N; k++) begin : g_duty
    localparam int D = (k * PWM_PERIOD) / mcp_pkg::SPEED_FULL;
    assign duty_tbl[k] = PH_W'(D);
  end

  assign duty      = duty_tbl[speed_r];
  assign phase_inc = {1'b0, phase_r} + 1'b1;
  assign idle_inc  = {1'b0, idle_r} + 1'b1;
  assign to_hit    = idle_inc > {1'b0, timeout_r};

  // next state for one accepted word
  always_comb begin
    move_nxt  = move_r;
    speed_nxt = speed_r;
    idle_nxt  = idle_r;
    phase_nxt = phase_r;
    pins_nxt  = pins_r;
    chan_on   = 1'b0;
    result    = '{timed_out: 1'b0, pins: pins_r};
    if (item.cmd) begin
      move_nxt  = item.move;
      speed_nxt = item.speed;
      idle_nxt  = '0;
    end else begin
      // phase wraps at the period
      phase_nxt = (phase_inc >= (PH_W + 1)'(PWM_PERIOD)) ? '0 : phase_inc[PH_W-1:0];
      chan_on   = (phase_nxt <= duty) && (duty != '0);
      pins_nxt  = chan_on ? ~mcp_pkg::chan_mask(move_r) : '1;
      // idle count saturates at the timeout and forces stop
      if (to_hit) begin
        idle_nxt  = timeout_r;
        move_nxt  = mcp_pkg::MOVE_STOP;
        speed_nxt = '0;
      end else begin
        idle_nxt = idle_inc[mcp_pkg::TIMEOUT_W-1:0];
      end
      result = '{timed_out: to_hit, pins: pins_nxt};
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= mcp_pkg::TIMEOUT_RST;
      move_r    <= mcp_pkg::MOVE_STOP;
      speed_r   <= '0;
      idle_r    <= '0;
      phase_r   <= '0;
      pins_r    <= '1;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (step) begin
        move_r  <= move_nxt;
        speed_r <= speed_nxt;
        idle_r  <= idle_nxt;
        phase_r <= phase_nxt;
        pins_r  <= pins_nxt;
      end
    end
  end

  assign held_speed = speed_r;

endmodule

@@ rtl/motor_command_pwm_with_timeout_unit.sv @@
// ----------------------------------------------------------------------------
// motor_command_pwm_with_timeout_unit
// four-channel pwm motor driver with command timeout, stream in and out
// ----------------------------------------------------------------------------
// Takes one word per clock while out_tready stays high: a tick
// (in_tuser = 0) or a new motion command (in_tuser = 1), and gives exactly
// one result word for each. A word waits in the input register, where the
// held command, phase and idle counters are updated in a single pass, and
// its result lands in the output register. Pins are active-low. timeout_ticks
// resets to 1000 and is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while the block is idle, the block does not enforce this.
module motor_command_pwm_with_timeout_unit #(
  parameter int PWM_PERIOD = mcp_pkg::PWM_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // move[2:0], speed[6:3], zero[7]
  input  logic        in_tuser,   // cmd[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // pin_a[0], pin_b[1], pin_c[2], pin_d[3],
                                  // timed_out[4], zero[7:5]
);

  logic               in_vld_r;
  mcp_pkg::item_t     item_r;
  logic               out_vld_r;
  mcp_pkg::result_t   res_r;
  mcp_pkg::result_t   res_now;
  logic               adv;
  logic [mcp_pkg::SPEED_W-1:0] held_speed;

  // input word moves on when the result register is free
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= '{cmd: in_tuser, move: in_tdata[2:0], speed: in_tdata[6:3]};
    end
  end

  mcp_core #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (adv),
    .item        (item_r),
    .result      (res_now),
    .held_speed  (held_speed)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_now;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, res_r.timed_out, res_r.pins};

  // checks
`include "motor_command_pwm_with_timeout_unit_assert.svh"

  `MCP_ASSERT_NEXT(a_cmd_no_timeout, adv && item_r.cmd, out_tvalid && !out_tdata[4])
  `MCP_ASSERT_NEXT(a_zero_speed_off, adv && !item_r.cmd && held_speed == '0,
                   out_tdata[3:0] == 4'b1111)
  `MCP_ASSERT_NOW(a_ready_when_empty, !in_tready, in_vld_r && out_vld_r)

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stream testbench for the four-channel pwm motor driver with command timeout
// ----------------------------------------------------------------------------
// Command and tick words go into the block, and an in-bench model of the held
// command, the phase counter and the idle counter predicts every result word.
// A directed pass goes through each move code, the speed extremes and the
// timeout corner cases. Random passes follow: command-then-tick runs at
// several timeout settings, with random gaps on the sender and random stalls
// on the receiver.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD      = mcp_pkg::PWM_PERIOD_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  // model of the block's state
  logic [15:0]                m_timeout = mcp_pkg::TIMEOUT_RST;
  logic [mcp_pkg::MOVE_W-1:0] m_move = mcp_pkg::MOVE_STOP;
  logic [3:0]                 m_speed = '0;
  logic [15:0]                m_idle = '0;
  logic [9:0]                 m_phase = '0;
  logic [3:0]                 m_pins = 4'hF;

  // results still owed by the block, oldest first
  mcp_pkg::result_t pin_word_q[$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;
  int n_cmd = 0;
  int n_tick = 0;
  int n_timeouts = 0;
  int n_cfg = 0;

  motor_command_pwm_with_timeout_unit #(.PWM_PERIOD(PERIOD)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // channels that take the duty for a move code, bit 0 is channel a
  function automatic logic [3:0] driven_channels(input logic [mcp_pkg::MOVE_W-1:0] mv);
    case (mv)
      mcp_pkg::MOVE_FORWARD:    return 4'b0011;
      mcp_pkg::MOVE_BACKWARD:   return 4'b1100;
      mcp_pkg::MOVE_LEFT:       return 4'b0010;
      mcp_pkg::MOVE_RIGHT:      return 4'b0001;
      mcp_pkg::MOVE_FAST_RIGHT: return 4'b1001;
      mcp_pkg::MOVE_FAST_LEFT:  return 4'b0110;
      default:                  return 4'b0000;
    endcase
  endfunction

  // advance the model by one accepted word and return the pin word it gives
  task automatic pwm_advance(input logic is_cmd, input logic [mcp_pkg::MOVE_W-1:0] mv,
                             input logic [3:0] sp, output mcp_pkg::result_t r);
    int duty;
    int nxt;
    logic [3:0] on;
    r.timed_out = 1'b0;
    if (is_cmd) begin
      m_move = mv;
      m_speed = sp;
      m_idle = '0;
      r.pins = m_pins;
      return;
    end
    duty = int'(m_speed) * PERIOD / mcp_pkg::SPEED_FULL;
    on = driven_channels(m_move);
    nxt = int'(m_phase) + 1;
    if (nxt >= PERIOD) nxt = 0;
    m_phase = nxt[9:0];
    if (!(int'(m_phase) <= duty && duty > 0)) on = '0;
    m_pins = ~on;
    nxt = int'(m_idle) + 1;
    if (nxt > int'(m_timeout)) begin
      nxt = int'(m_timeout);
      m_move = mcp_pkg::MOVE_STOP;
      m_speed = '0;
      r.timed_out = 1'b1;
    end
    m_idle = nxt[15:0];
    r.pins = m_pins;
  endtask

  // send one word, with random gaps before it
  task automatic send_word(input logic is_cmd, input logic [mcp_pkg::MOVE_W-1:0] mv,
                           input logic [3:0] sp);
    mcp_pkg::result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= is_cmd;
    in_tdata <= {1'b0, sp, mv};
    do @(posedge clk); while (!in_tready);
    pwm_advance(is_cmd, mv, sp, r);
    pin_word_q.push_back(r);
    if (is_cmd) n_cmd++;
    else n_tick++;
  endtask

  // hold off the sender until every owed result has come out
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pin_word_q.size() > 0) @(posedge clk);
  endtask

  // write timeout_ticks with the block idle
  task automatic write_timeout(input logic [15:0] value);
    drain_results();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    m_timeout = value;
    n_cfg++;
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch on %s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    mcp_pkg::result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pin_word_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result word with nothing owed: %02h", out_tdata);
      end else begin
        exp_r = pin_word_q.pop_front();
        check_field("pin_a", int'(exp_r.pins[0]), int'(out_tdata[0]));
        check_field("pin_b", int'(exp_r.pins[1]), int'(out_tdata[1]));
        check_field("pin_c", int'(exp_r.pins[2]), int'(out_tdata[2]));
        check_field("pin_d", int'(exp_r.pins[3]), int'(out_tdata[3]));
        check_field("timed_out", int'(exp_r.timed_out), int'(out_tdata[4]));
        check_field("padding", 0, int'(out_tdata[7:5]));
        if (exp_r.timed_out) n_timeouts++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles", cycles);
      $display("tb failed");
      $finish;
    end
  end

  // every move code incl. the unused one, speed extremes, speed zero
  task automatic test_moves();
    int mv;
    for (mv = 0; mv < 8; mv++) begin
      send_word(1'b1, mv[2:0], (mv % 2 == 0) ? 4'd15 : 4'd9);
      send_word(1'b0, 3'd7, 4'd15);
    end
    send_word(1'b1, mcp_pkg::MOVE_FORWARD, 4'd0);
    send_word(1'b0, mcp_pkg::MOVE_STOP, 4'd0);
  endtask

  // zero timeout forces stop on every tick, small timeout saturates
  task automatic test_timeout_corners();
    write_timeout(16'd0);
    send_word(1'b1, mcp_pkg::MOVE_FAST_RIGHT, 4'd15);
    send_word(1'b0, mcp_pkg::MOVE_STOP, 4'd0);
    send_word(1'b0, mcp_pkg::MOVE_STOP, 4'd0);
    write_timeout(16'd2);
    send_word(1'b1, mcp_pkg::MOVE_BACKWARD, 4'd15);
    repeat (4) send_word(1'b0, mcp_pkg::MOVE_STOP, 4'd0);
  endtask

  // commands followed by random runs of ticks, at most the timeout plus four and never over 60
  task automatic test_random_runs(input int n_words, input logic [15:0] timeout_val,
                                  input int gap_pct, input int stall_pct);
    int sent;
    int run;
    int run_max;
    write_timeout(timeout_val);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    run_max = (int'(timeout_val) + 4 > 60) ? 60 : int'(timeout_val) + 4;
    while (sent < n_words) begin
      if ($urandom_range(9) == 0)
        send_word(1'b0, 3'($urandom_range(7)), 4'($urandom_range(15)));
      else
        send_word(1'b1, 3'($urandom_range(7)), 4'($urandom_range(15)));
      sent++;
      run = $urandom_range(run_max);
      repeat (run) send_word(1'b0, 3'($urandom_range(7)), 4'($urandom_range(15)));
      sent += run;
      if ($urandom_range(39) == 0) drain_results();
    end
    send_gap_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_moves();
    test_timeout_corners();

    test_random_runs(150, mcp_pkg::TIMEOUT_RST, 0, 0);
    test_random_runs(150, 16'hFFFF, 52, 0);
    test_random_runs(150, 16'd1, 0, 52);
    test_random_runs(100, 16'd0, 35, 35);
    test_random_runs(150, 16'($urandom_range(40, 2)), 0, 0);
    test_random_runs(150, 16'($urandom_range(30, 3)), 52, 0);
    test_random_runs(200, 16'($urandom_range(12, 1)), 35, 35);

    // settle and look for stray results
    drain_results();
    repeat (10) @(posedge clk);
    if (pin_word_q.size() != 0) mismatches++;

    $display("covered %0d commands and %0d ticks, %0d forced stops, %0d timeout writes",
             n_cmd, n_tick, n_timeouts, n_cfg);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
